### hw/rtl/sq2d_pkg.sv
// ----------------------------------------------------------------------------
// sq2d_pkg
// Shared constants and helpers for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package sq2d_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned FD_W    = 3;

	localparam logic [FD_W-1:0] FD_LAST = 3'd7;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

	function automatic logic [3:0] dabble_adj(input logic [3:0] d);
		dabble_adj = (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

### hw/rtl/sq2d_bcd.sv
// ----------------------------------------------------------------------------
// sq2d_bcd
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
// ----------------------------------------------------------------------------
module sq2d_bcd #(
	parameter int unsigned IW = 8,
	parameter int unsigned ND = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [IW-1:0]   bin,
	output logic            done,
	output logic [4*ND-1:0] bcd
);

	localparam int unsigned CW = $clog2(IW);

	logic [IW-1:0]   bin_q;
	logic [4*ND-1:0] bcd_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [4*ND-1:0] adj;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			adj[4*i +: 4] = sq2d_pkg::dabble_adj(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(IW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[IW-2:0], 1'b0};
			bcd_q <= {adj[4*ND-2:0], bin_q[IW-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

### hw/rtl/signed_q8_8_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_q8_8_to_decimal_ascii
// Converts a signed fixed-point value into its decimal ASCII text.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays high
// until the cycle in which the last character is registered, and that character
// is shown in the first cycle in which busy is low. The (16 - FRAC_BITS)-bit
// integer part is first turned into BCD by an iterative shift-and-adjust unit.
// Then come the sign (for a negative value), each integer digit position in
// turn (leading zero positions give no character), and, when the fraction is
// not zero, the point and every fraction digit, the latter from a shared
// multiply-by-ten step. Each character is shown for exactly one cycle with
// strobe high and last marks the final one; the receiver cannot stall the
// output.
// ----------------------------------------------------------------------------
module signed_q8_8_to_decimal_ascii #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [sq2d_pkg::VALUE_W-1:0] value,
	output logic                               strobe,
	output logic [sq2d_pkg::CHAR_W-1:0]        ch,
	output logic                               last
);

	localparam int unsigned IW = sq2d_pkg::VALUE_W - FRAC_BITS;
	localparam int unsigned ND = (IW * 3) / 10 + 1;
	localparam int unsigned RW = $clog2(ND + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_INT,
		S_DOT,
		S_FRAC
	} state_t;

	state_t                        state_q;
	logic                          neg_q;
	logic [FRAC_BITS-1:0]          frac_q;
	logic [4*ND-1:0]               digs_q;
	logic [RW-1:0]                 rem_q;
	logic                          started_q;
	logic [sq2d_pkg::FD_W-1:0]     fd_q;
	logic                          strobe_q;
	logic [sq2d_pkg::CHAR_W-1:0]   ch_q;
	logic                          last_q;

	logic                          accept;
	logic [sq2d_pkg::VALUE_W-1:0]  mag;
	logic                          bcd_done;
	logic [4*ND-1:0]               bcd;
	logic [3:0]                    top_dig;
	logic                          last_dig;
	logic [FRAC_BITS+3:0]          prod;
	logic [FRAC_BITS-1:0]          next_frac;

	assign accept   = start && !busy;
	assign mag      = value[sq2d_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
	assign top_dig  = digs_q[4*ND-1 -: 4];
	assign last_dig = (rem_q == RW'(1));
	assign prod     = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
	assign next_frac = prod[FRAC_BITS-1:0];

	sq2d_bcd #(
		.IW(IW),
		.ND(ND)
	) u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (accept),
		.bin   (mag[sq2d_pkg::VALUE_W-1:FRAC_BITS]),
		.done  (bcd_done),
		.bcd   (bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			strobe_q  <= 1'b0;
			ch_q      <= '0;
			last_q    <= 1'b0;
			started_q <= 1'b0;
			rem_q     <= '0;
			fd_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (bcd_done) begin
						rem_q     <= RW'(ND);
						started_q <= 1'b0;
						state_q   <= neg_q ? S_SIGN : S_INT;
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					ch_q     <= sq2d_pkg::CH_MINUS;
					state_q  <= S_INT;
				end
				S_INT: begin
					if (top_dig != 4'd0 || started_q || last_dig) begin
						strobe_q  <= 1'b1;
						ch_q      <= sq2d_pkg::CH_ZERO + {3'b0, top_dig};
						last_q    <= last_dig && (frac_q == '0);
						started_q <= 1'b1;
					end
					rem_q <= rem_q - 1'b1;
					if (last_dig) begin
						state_q <= (frac_q != '0) ? S_DOT : S_IDLE;
					end
				end
				S_DOT: begin
					strobe_q <= 1'b1;
					ch_q     <= sq2d_pkg::CH_POINT;
					fd_q     <= '0;
					state_q  <= S_FRAC;
				end
				S_FRAC: begin
					strobe_q <= 1'b1;
					ch_q     <= sq2d_pkg::CH_ZERO + {3'b0, prod[FRAC_BITS+3:FRAC_BITS]};
					fd_q     <= fd_q + 1'b1;
					if (next_frac == '0 || fd_q == sq2d_pkg::FD_LAST) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= value[sq2d_pkg::VALUE_W-1];
			frac_q <= mag[FRAC_BITS-1:0];
		end else if (state_q == S_FRAC) begin
			frac_q <= next_frac;
		end
		if (state_q == S_CONV && bcd_done) begin
			digs_q <= bcd;
		end else if (state_q == S_INT) begin
			digs_q <= {digs_q[4*ND-5:0], 4'b0};
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign ch     = ch_q;
	assign last   = last_q;

	// A character only ever follows a cycle in which a request was in progress.
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without a request in progress");

	// An accepted request makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// Fraction digits are only produced while some fraction remains.
	a_frac_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAC) |-> (frac_q != '0))
		else $error("fraction digit state with empty fraction");

	// The final-character flag never appears without a character.
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

endmodule
